@@ hw/rtl/gulpp_pkg.sv @@
// Shared types and constants for the GIF LZW pixel packer.
`default_nettype none
package gulpp_pkg;

   // LZW control codes for a 9-bit code size
   localparam logic [8:0] CODE_CLEAR = 9'd256;
   localparam logic [8:0] CODE_END   = 9'd257;

   // configuration register indexes
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   // one pixel's worth of work for the back end
   typedef struct packed {
      logic [7:0]  pix;       // RGB332 literal
      logic        start;     // frame opens: clear code first, reload counters
      logic        clear;     // periodic clear code before the literal
      logic        end_code;  // last pixel: end code, flush, terminator
      logic [32:0] total;     // frame data byte count, valid with start
   } tok_type;

   typedef enum logic [2:0] {
      FR_RUN,
      FR_MUL,
      FR_PREP,
      FR_DIV,
      FR_SUM,
      FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LOAD,
      BK_EMIT,
      BK_TERM
   } back_state_type;

endpackage
`default_nettype wire

@@ hw/rtl/gulpp_if.sv @@
// Valid/ready channel interfaces for pixel requests and byte responses.
`default_nettype none
interface gulpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface gulpp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       frame_done;
   modport source (output valid, output out_byte, output run_last, output frame_done,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input frame_done,
                   output ready);
endinterface
`default_nettype wire

@@ hw/rtl/gulpp_queue.sv @@
// Small token queue between the pixel front end and the byte back end.
`default_nettype none
module gulpp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gulpp_pkg::tok_type push_tok,
   output logic              full,
   input  logic              pop,
   output gulpp_pkg::tok_type head_tok,
   output logic              empty
);
   import gulpp_pkg::*;

   tok_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_tok = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_tok;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/gulpp_front.sv @@
// Front end: takes pixels, quantizes, tracks frame and clear counts, sizes the frame.
`default_nettype none
module gulpp_front #(
   parameter int CLEAR_INTERVAL = 250
) (
   input  logic               clock,
   input  logic               reset,
   gulpp_req_if.sink          req,
   input  logic [15:0]        image_width,
   input  logic [15:0]        image_height,
   output logic               push,
   output gulpp_pkg::tok_type push_tok,
   input  logic               q_full
);
   import gulpp_pkg::*;

   localparam logic [7:0]  CI8 = 8'(CLEAR_INTERVAL);
   // ceil(2^40 / interval): exact floor for any 32-bit dividend and interval below 256
   localparam logic [63:0] RECIP64 = ((64'd1 << 40) + 64'(CLEAR_INTERVAL) - 64'd1) /
                                     64'(CLEAR_INTERVAL);
   localparam logic [47:0] RECIP   = RECIP64[47:0];

   front_state_type state_ff, state_in;
   logic [31:0] pixels_left_ff, pixels_left_in;
   logic [7:0]  lits_ff, lits_in;
   logic [7:0]  pix_ff, pix_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [49:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [32:0] codes_ff, codes_in;

   logic        accept;
   logic [7:0]  pix_now;
   logic [15:0] w1, h1;
   logic [15:0] chunk;
   logic [47:0] part48;
   logic [36:0] bits37;
   logic        clr_now, end_now;

   assign accept  = req.valid & req.ready;
   assign pix_now = {req.red[7:5], req.green[7:5], req.blue[7:6]};
   assign clr_now = (lits_ff >= CI8);
   assign end_now = (pixels_left_ff == 32'd1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_RUN:  if (accept && pixels_left_ff == '0) state_in = FR_MUL;
         FR_MUL:  state_in = FR_PREP;
         FR_PREP: state_in = FR_DIV;
         FR_DIV:  if (cnt_ff == 2'd2) state_in = FR_SUM;
         FR_SUM:  state_in = FR_PUSH;
         FR_PUSH: if (!q_full) state_in = FR_RUN;
         default: state_in = FR_RUN;
      endcase
   end

   // handshake and queue write
   always_comb begin
      req.ready = 1'b0;
      push      = 1'b0;
      unique case (state_ff)
         FR_RUN: begin
            req.ready = !q_full;
            push      = accept && (pixels_left_ff != '0);
         end
         FR_PUSH: push = !q_full;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      pixels_left_in = pixels_left_ff;
      lits_in        = lits_ff;
      pix_in         = pix_ff;
      prod_in        = prod_ff;
      dvd_in         = dvd_ff;
      acc_in         = acc_ff;
      cnt_in         = cnt_ff;
      codes_in       = codes_ff;
      w1             = (image_width  == '0) ? 16'd1 : image_width;
      h1             = (image_height == '0) ? 16'd1 : image_height;
      // reciprocal taken 16 bits per step, low part first
      case (cnt_ff)
         2'd0:    chunk = RECIP[15:0];
         2'd1:    chunk = RECIP[31:16];
         default: chunk = RECIP[47:32];
      endcase
      part48         = {16'b0, dvd_ff} * {32'b0, chunk};
      bits37         = ({4'b0, codes_ff} << 3) + {4'b0, codes_ff} + 37'd7;

      push_tok.pix      = pix_now;
      push_tok.start    = 1'b0;
      push_tok.clear    = clr_now;
      push_tok.end_code = end_now;
      push_tok.total    = '0;

      unique case (state_ff)
         FR_RUN: begin
            if (accept) begin
               if (pixels_left_ff == '0) begin
                  pix_in = pix_now;
               end else begin
                  pixels_left_in = pixels_left_ff - 32'd1;
                  if (end_now)      lits_in = '0;
                  else if (clr_now) lits_in = 8'd1;
                  else              lits_in = lits_ff + 8'd1;
               end
            end
         end
         FR_MUL: prod_in = {16'b0, w1} * {16'b0, h1};
         FR_PREP: begin
            dvd_in = prod_ff - 32'd1;
            acc_in = '0;
            cnt_in = '0;
         end
         FR_DIV: begin
            // low 16 bits of the running sum never carry into the kept part
            acc_in = {16'b0, acc_ff[49:16]} + {2'b0, part48};
            cnt_in = cnt_ff + 2'd1;
         end
         FR_SUM: codes_in = {1'b0, prod_ff} + {1'b0, acc_ff[39:8]} + 33'd2;
         FR_PUSH: begin
            push_tok.pix      = pix_ff;
            push_tok.start    = 1'b1;
            push_tok.clear    = 1'b0;
            push_tok.end_code = (prod_ff == 32'd1);
            push_tok.total    = bits37[35:3];
            if (!q_full) begin
               pixels_left_in = prod_ff - 32'd1;
               lits_in        = (prod_ff == 32'd1) ? 8'd0 : 8'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FR_RUN;
         pixels_left_ff <= '0;
         lits_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         pixels_left_ff <= pixels_left_in;
         lits_ff        <= lits_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff   <= pix_in;
      prod_ff  <= prod_in;
      dvd_ff   <= dvd_in;
      acc_ff   <= acc_in;
      cnt_ff   <= cnt_in;
      codes_ff <= codes_in;
   end
endmodule
`default_nettype wire

@@ hw/rtl/gulpp_back.sv @@
// Back end: packs 9-bit codes LSB first into sub-blocked bytes, one code at a time.
`default_nettype none
module gulpp_back #(
   parameter int SUBBLOCK_BYTES = 255
) (
   input  logic               clock,
   input  logic               reset,
   input  gulpp_pkg::tok_type head_tok,
   input  logic               q_empty,
   output logic               pop,
   gulpp_rsp_if.source        rsp
);
   import gulpp_pkg::*;

   localparam int         LIM  = (SUBBLOCK_BYTES < 3) ? 3 : SUBBLOCK_BYTES;
   localparam logic [7:0] LIM8 = 8'(LIM);

   back_state_type state_ff, state_in;
   logic [7:0]  pix_ff, pix_in;
   logic [3:0]  todo_ff, todo_in;    // {end, literal, clear, start} codes still due
   logic        end_ff, end_in;
   logic [15:0] acc_ff, acc_in;
   logic [4:0]  nb_ff, nb_in;
   logic [7:0]  pend_ff, pend_in;
   logic [2:0]  pc_ff, pc_in;
   logic [7:0]  bls_ff, bls_in;
   logic [32:0] dbl_ff, dbl_in;
   logic        vld_ff, vld_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        done_ff, done_in;

   logic        out_free;
   logic        emit_go;     // EMIT or TERM can place a byte this cycle
   logic        need_len;
   logic        code_done;   // current code's full bytes are out after this one
   logic [4:0]  nb_left;
   logic [8:0]  code9;
   logic [7:0]  len8;
   logic        finish;      // token fully sent this cycle

   assign out_free  = !vld_ff || rsp.ready;
   assign need_len  = (bls_ff == '0);
   assign nb_left   = nb_ff - 5'd8;
   assign code_done = (nb_left < 5'd8);
   assign len8      = (dbl_ff == '0) ? 8'd1 :
                      (dbl_ff < {25'b0, LIM8}) ? dbl_ff[7:0] : LIM8;

   always_comb begin
      if (todo_ff[0] || todo_ff[1]) code9 = CODE_CLEAR;
      else if (todo_ff[2])          code9 = {1'b0, pix_ff};
      else                          code9 = CODE_END;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      finish   = 1'b0;
      unique case (state_ff)
         BK_IDLE: if (!q_empty) state_in = BK_LOAD;
         BK_LOAD: state_in = BK_EMIT;
         BK_EMIT: begin
            if (out_free && !need_len && code_done) begin
               if (todo_ff != '0)            state_in = BK_LOAD;
               else if (end_ff) begin
                  if (nb_left == '0)         state_in = BK_TERM;
               end else                      finish   = 1'b1;
            end
         end
         BK_TERM: if (out_free) finish = 1'b1;
         default: state_in = BK_IDLE;
      endcase
      if (finish) state_in = q_empty ? BK_IDLE : BK_LOAD;
   end

   // queue pop and output byte; a waiting byte holds until taken
   always_comb begin
      emit_go = 1'b0;
      byte_in = byte_ff;
      last_in = last_ff;
      done_in = done_ff;
      unique case (state_ff)
         BK_EMIT: begin
            emit_go = out_free;
            if (out_free) begin
               byte_in = need_len ? len8 : acc_ff[7:0];
               last_in = !need_len && code_done && (todo_ff == '0) && !end_ff;
               done_in = 1'b0;
            end
         end
         BK_TERM: begin
            emit_go = out_free;
            if (out_free) begin
               byte_in = 8'h00;
               last_in = 1'b1;
               done_in = 1'b1;
            end
         end
         default: ;
      endcase
      pop = (state_ff == BK_IDLE && !q_empty) || (finish && !q_empty);
      if (emit_go)      vld_in = 1'b1;
      else if (out_free) vld_in = 1'b0;
      else              vld_in = vld_ff;
   end

   // packing datapath
   always_comb begin
      pix_in  = pix_ff;
      todo_in = todo_ff;
      end_in  = end_ff;
      acc_in  = acc_ff;
      nb_in   = nb_ff;
      pend_in = pend_ff;
      pc_in   = pc_ff;
      bls_in  = bls_ff;
      dbl_in  = dbl_ff;
      unique case (state_ff)
         BK_LOAD: begin
            acc_in = {8'b0, pend_ff} | (16'(code9) << pc_ff);
            nb_in  = 5'(pc_ff) + 5'd9;
            if (todo_ff[0])      todo_in[0] = 1'b0;
            else if (todo_ff[1]) todo_in[1] = 1'b0;
            else if (todo_ff[2]) todo_in[2] = 1'b0;
            else                 todo_in[3] = 1'b0;
         end
         BK_EMIT: begin
            if (out_free) begin
               if (need_len) begin
                  bls_in = len8;
               end else begin
                  bls_in = bls_ff - 8'd1;
                  if (dbl_ff != '0) dbl_in = dbl_ff - 33'd1;
                  acc_in = {8'b0, acc_ff[15:8]};
                  nb_in  = nb_left;
                  if (code_done) begin
                     pend_in = acc_ff[15:8];
                     pc_in   = nb_left[2:0];
                     // last code of the frame: flush leftover bits as one byte
                     if (todo_ff == '0 && end_ff && nb_left != '0) nb_in = 5'd8;
                  end
               end
            end
         end
         BK_TERM: begin
            if (out_free) begin
               bls_in  = '0;
               dbl_in  = '0;
               pend_in = '0;
               pc_in   = '0;
            end
         end
         default: ;
      endcase
      if (pop) begin
         pix_in  = head_tok.pix;
         todo_in = {head_tok.end_code, 1'b1, head_tok.clear, head_tok.start};
         end_in  = head_tok.end_code;
         if (head_tok.start) begin
            dbl_in  = head_tok.total;
            pend_in = '0;
            pc_in   = '0;
            bls_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         vld_ff   <= 1'b0;
         pend_ff  <= '0;
         pc_ff    <= '0;
         bls_ff   <= '0;
         dbl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         pend_ff  <= pend_in;
         pc_ff    <= pc_in;
         bls_ff   <= bls_in;
         dbl_ff   <= dbl_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff  <= pix_in;
      todo_ff <= todo_in;
      end_ff  <= end_in;
      acc_ff  <= acc_in;
      nb_ff   <= nb_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp.valid      = vld_ff;
   assign rsp.out_byte   = byte_ff;
   assign rsp.run_last   = last_ff;
   assign rsp.frame_done = done_ff;
endmodule
`default_nettype wire

@@ hw/rtl/gif_uncompressed_lzw_pixel_packer_top.sv @@
// Top level of the GIF 9-bit uncompressed LZW pixel packer.
`default_nettype none
//
//  channel   dir  beat                                  handshake
//  req_chan  in   red, green, blue (8b each)            valid/ready
//  rsp_chan  out  out_byte (8b), run_last, frame_done   valid/ready
//  csr_*     in   index (1b), wdata (16b)               csr_wr_en, no wait
//
//  A pixel inside a frame is accepted while the queue has room, so the front
//  takes pixels while the back end packs earlier ones. The back end loads
//  each code and then emits its stream bytes (1-2 per code, plus sub-block
//  length bytes); a held output byte stalls the back end. The first pixel of
//  a frame holds req ready low while the front end works: a multiply, three
//  reciprocal-multiply steps by the clear interval, a sum and the queue write
//  size the frame's byte count. Reset is synchronous and empties the queue and
//  output register. Either side may stall; the 4-beat queue and the output
//  register let the front keep accepting while a byte waits.
//
module gif_uncompressed_lzw_pixel_packer_top #(
   parameter int SUBBLOCK_BYTES = 255,
   parameter int CLEAR_INTERVAL = 250
) (
   input  logic        clock,
   input  logic        reset,
   gulpp_req_if.sink   req_chan,
   gulpp_rsp_if.source rsp_chan,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import gulpp_pkg::*;

   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;

   logic    push, pop, q_full, q_empty;
   tok_type push_tok, head_tok;

   // frame size registers; the front samples them at frame start
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 16'd1;
         height_ff <= 16'd1;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   gulpp_front #(
      .CLEAR_INTERVAL (CLEAR_INTERVAL)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .image_width  (width_ff),
      .image_height (height_ff),
      .push         (push),
      .push_tok     (push_tok),
      .q_full       (q_full)
   );

   gulpp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_tok (push_tok),
      .full     (q_full),
      .pop      (pop),
      .head_tok (head_tok),
      .empty    (q_empty)
   );

   gulpp_back #(
      .SUBBLOCK_BYTES (SUBBLOCK_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head_tok (head_tok),
      .q_empty  (q_empty),
      .pop      (pop),
      .rsp      (rsp_chan)
   );
endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the GIF LZW pixel packer: predicts the byte stream per pixel.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gulpp_pkg::*;

   // block build under test
   localparam int SUB_BYTES   = 255;
   localparam int CLEAR_EVERY = 250;
   // sub-blocks below 3 bytes behave as 3
   localparam int SUB_LIMIT   = (SUB_BYTES < 3) ? 3 : SUB_BYTES;

   localparam int SETTLE_CYCLES  = 60;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       done;
   } stream_beat_type;

   // Byte-stream tracker: mirrors the packer state and queues the beats each
   // accepted pixel must produce.
   class gif_byte_stream_type;
      stream_beat_type due[$];
      stream_beat_type step_beats[$];
      int              fails;
      logic [15:0]     width_reg;
      logic [15:0]     height_reg;
      bit [31:0]       pixels_left;
      bit [7:0]        lits_since_clear;
      bit [7:0]        held_bits;
      int unsigned     held_count;
      bit [7:0]        block_left;
      bit [32:0]       bytes_left;

      function new();
         fails            = 0;
         width_reg        = 16'd1;
         height_reg       = 16'd1;
         pixels_left      = '0;
         lits_since_clear = '0;
         held_bits        = '0;
         held_count       = 0;
         block_left       = '0;
         bytes_left       = '0;
      endfunction

      function void set_reg(logic idx, logic [15:0] val);
         if (idx == CSR_IMAGE_WIDTH) begin
            width_reg = val;
         end else begin
            height_reg = val;
         end
      endfunction

      function void push_beat(logic [7:0] b, logic done);
         stream_beat_type beat;
         beat.data = b;
         beat.last = 1'b0;
         beat.done = done;
         step_beats.push_back(beat);
      endfunction

      // data byte, opening a sub-block with its length byte when needed
      function void push_data(logic [7:0] b);
         longint unsigned len;
         if (block_left == 0) begin
            len = (bytes_left < SUB_LIMIT) ? bytes_left : SUB_LIMIT;
            if (len == 0) len = 1;
            push_beat(len[7:0], 1'b0);
            block_left = len[7:0];
         end
         push_beat(b, 1'b0);
         block_left--;
         if (bytes_left != 0) bytes_left--;
      endfunction

      // LSB-first packing of one 9-bit code
      function void pack_code(logic [8:0] code);
         bit [16:0]   acc;
         int unsigned n;
         acc = {9'd0, held_bits} | (17'(code) << held_count);
         n   = held_count + 9;
         while (n >= 8) begin
            push_data(acc[7:0]);
            acc = acc >> 8;
            n   = n - 8;
         end
         held_bits  = acc[7:0];
         held_count = n;
      endfunction

      function void take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         logic [7:0]      pix;
         longint unsigned w, h, npix, codes;
         pix = {r[7:5], g[7:5], b[7:6]};
         step_beats.delete();

         if (pixels_left == 0) begin
            // frame start: dimensions sampled, zero counts as one
            w                = (width_reg == 0) ? 1 : width_reg;
            h                = (height_reg == 0) ? 1 : height_reg;
            npix             = w * h;
            codes            = 2 + npix + (npix - 1) / CLEAR_EVERY;
            pixels_left      = npix[31:0];
            bytes_left       = 33'((codes * 9 + 7) / 8);
            lits_since_clear = '0;
            held_bits        = '0;
            held_count       = 0;
            block_left       = '0;
            pack_code(CODE_CLEAR);
         end

         if (lits_since_clear >= CLEAR_EVERY) begin
            pack_code(CODE_CLEAR);
            lits_since_clear = '0;
         end
         pack_code({1'b0, pix});
         lits_since_clear++;
         pixels_left--;

         if (pixels_left == 0) begin
            // frame end: end code, flush partial byte, terminator
            pack_code(CODE_END);
            if (held_count != 0) begin
               push_data(held_bits);
               held_bits  = '0;
               held_count = 0;
            end
            push_beat(8'd0, 1'b1);
            block_left       = '0;
            bytes_left       = '0;
            lits_since_clear = '0;
         end

         if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
         foreach (step_beats[i]) due.push_back(step_beats[i]);
      endfunction

      function void match_byte(logic [7:0] b, logic last, logic done);
         stream_beat_type want;
         if (due.size() == 0) begin
            $error("unexpected beat: out_byte %02h run_last %0b frame_done %0b",
                   b, last, done);
            fails++;
            return;
         end
         want = due.pop_front();
         if (b !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, b);
            fails++;
         end
         if (last !== want.last) begin
            $error("run_last: expected %0b, actual %0b", want.last, last);
            fails++;
         end
         if (done !== want.done) begin
            $error("frame_done: expected %0b, actual %0b", want.done, done);
            fails++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [15:0] csr_wdata;

   gulpp_req_if req_chan ();
   gulpp_rsp_if rsp_chan ();

   gif_byte_stream_type stream = new();

   // idling controls for the sender and the receiver, and the watchdog count
   bit no_idle;
   bit hold_rsp;
   int quiet_cycles;

   gif_uncompressed_lzw_pixel_packer_top #(
      .SUBBLOCK_BYTES (SUB_BYTES),
      .CLEAR_INTERVAL (CLEAR_EVERY)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int idle_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Pixel component: extremes show up often, otherwise uniform.
   function automatic logic [7:0] pick_component();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hff;
      return 8'($urandom_range(0, 255));
   endfunction

   // Monitor: both channels are sampled at the edge, before any NBA lands.
   // Responses are checked before the same-edge pixel is queued; a byte can
   // never come from a pixel accepted at the same edge, so order is safe.
   // The watchdog shares this block: it counts edges with no beat at all.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            stream.match_byte(rsp_chan.out_byte, rsp_chan.run_last, rsp_chan.frame_done);
         end
         if (req_chan.valid && req_chan.ready) begin
            stream.take_pixel(req_chan.red, req_chan.green, req_chan.blue);
         end
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Receiver: random ready bursts and gaps. On request it holds ready low
   // for a long counted stretch so the queue fills and req ready drops.
   initial begin
      int burst;
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         burst = $urandom_range(1, 20);
         rsp_chan.ready <= 1'b1;
         repeat (burst) @(posedge clock);
         gap = idle_gap();
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // One pixel beat; valid stays up into the next beat unless a gap follows.
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.red   <= r;
      req_chan.green <= g;
      req_chan.blue  <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      gap = idle_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_pixels(input int count);
      for (int i = 0; i < count; i++) begin
         send_pixel(pick_component(), pick_component(), pick_component());
      end
   endtask

   // Sender pauses until every predicted byte is out, then lets the block settle.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (stream.due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      stream.set_reg(idx, val);
   endtask

   task automatic set_frame(input logic [15:0] w, input logic [15:0] h);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
   endtask

   initial begin
      int w;
      int h;
      int npix;
      int small_total;
      int frame_no;

      no_idle  = 1'b0;
      hold_rsp = 1'b0;
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_IMAGE_WIDTH;
      csr_wdata      <= '0;
      req_chan.valid <= 1'b0;
      req_chan.red   <= '0;
      req_chan.green <= '0;
      req_chan.blue  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // reset dimensions are 1x1: every pixel is a whole frame
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hff, 8'hff, 8'hff);
      send_pixel(8'hff, 8'h00, 8'h00);
      send_pixel(8'h00, 8'hff, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hff);
      send_pixel(8'h1f, 8'he3, 8'h3f);   // red and blue set only dropped bits; green sets all kept bits and two dropped
      drain();

      // zero width and height both count as one
      set_frame(16'd0, 16'd0);
      send_pixel(8'ha5, 8'h5a, 8'hc3);
      send_pixel(8'h5a, 8'ha5, 8'h3c);
      drain();

      // zero height alone
      set_frame(16'd3, 16'd0);
      send_pixel(8'he0, 8'h1c, 8'h03);
      send_pixel(8'h20, 8'h20, 8'h40);
      send_pixel(8'hff, 8'h00, 8'hff);
      drain();

      // tall single column
      set_frame(16'd1, 16'd5);
      send_random_pixels(5);
      drain();

      // --- random ---
      // one frame long enough for a periodic clear and a second sub-block
      w = $urandom_range(251, 262);
      set_frame(16'(w), 16'd1);
      send_random_pixels(w);
      drain();

      // a run of small frames with random dimensions, zero included
      small_total = 0;
      frame_no    = 0;
      while (frame_no < 3 || small_total < 40) begin
         w = $urandom_range(0, 7);
         h = $urandom_range(0, 7);
         if (frame_no == 1) begin
            // long receiver hold-off while the sender keeps pushing
            w = 4;
            h = 4;
            hold_rsp = 1'b1;
            wait (!hold_rsp);
         end
         no_idle = (frame_no == 2);
         set_frame(16'(w), 16'(h));
         npix = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
         send_random_pixels(npix);
         drain();
         no_idle     = 1'b0;
         small_total += npix;
         frame_no++;
      end

      // largest frame: byte count needs the full 33 bits; left open at the end
      set_frame(16'hffff, 16'hffff);
      send_random_pixels(8);
      drain();

      if (stream.fails == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/gulpp_pkg.sv
hw/rtl/gulpp_if.sv
hw/rtl/gulpp_queue.sv
hw/rtl/gulpp_front.sv
hw/rtl/gulpp_back.sv
hw/rtl/gif_uncompressed_lzw_pixel_packer_top.sv
dv/tb.sv
